// ===== hw/rtl/uvc_pkg.sv =====
// ----------------------------------------------------------------------------
// uvc_pkg
// Shared types and constants of the upwind vorticity cell update.
// ----------------------------------------------------------------------------
package uvc_pkg;

	localparam int FIELD_W         = 32;  // width of every value field
	localparam int COEF_W          = 32;  // Q2.30 coefficient width
	localparam int FRAC_W          = 16;  // fraction bits of a Q16.16 value
	localparam int COEF_FRAC_W     = 30;  // fraction bits of a coefficient
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int VALUE_WIDTH_MIN = 16;
	localparam int VALUE_WIDTH_MAX = 32;
	localparam int CFG_IDX_W       = 8;

	localparam logic [COEF_W-1:0] COEF_RESET = 32'd10737418;  // about 0.01

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ADV_X  = 8'd0,
		REG_ADV_Y  = 8'd1,
		REG_DIFF_X = 8'd2,
		REG_DIFF_Y = 8'd3
	} cfg_reg_t;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

endpackage

// ===== hw/rtl/uvc_if.sv =====
// ----------------------------------------------------------------------------
// uvc_in_if / uvc_out_if
// Valid/ready channels carrying one cell word in and one result word out.
// ----------------------------------------------------------------------------
interface uvc_in_if import uvc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] vort_center;
	logic [FIELD_W-1:0] vort_west;
	logic [FIELD_W-1:0] vort_east;
	logic [FIELD_W-1:0] vort_south;
	logic [FIELD_W-1:0] vort_north;
	logic [FIELD_W-1:0] vel_x;
	logic [FIELD_W-1:0] vel_y;
	logic               solid_cell;

	modport source (
		output valid, vort_center, vort_west, vort_east, vort_south, vort_north,
		       vel_x, vel_y, solid_cell,
		input  ready
	);
	modport sink (
		input  valid, vort_center, vort_west, vort_east, vort_south, vort_north,
		       vel_x, vel_y, solid_cell,
		output ready
	);
endinterface

interface uvc_out_if import uvc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] vort_next;
	logic               saturated;

	modport source (
		output valid, vort_next, saturated,
		input  ready
	);
	modport sink (
		input  valid, vort_next, saturated,
		output ready
	);
endinterface

// ===== hw/rtl/upwind_vorticity_cell_update.sv =====
// ----------------------------------------------------------------------------
// upwind_vorticity_cell_update
// Per-cell explicit vorticity step: first-order upwind advection on each axis
// plus five-point Laplacian diffusion, saturated to the value range.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake           word
//  ---------  ---  ------------------  -----------------------------------------
//  cell_in    in   valid/ready         center, W, E, S, N vorticity, vel x/y,
//                                      solid flag
//  cell_out   out  valid/ready         vort_next, saturated
//  cfg        in   cfg_we (no ready)   cfg_index selects one of four Q2.30 coefs
//
//  One word per cycle sustained while cell_out.ready stays high; the seven
//  register stages lie between accept and cell_out.valid.
//  Each stage advances when it is empty or the stage after it advances, so
//  bubbles close up and words are taken while a result waits at the output.
//  arst_n clears the valid bits and loads the coefficients with about 0.01.
//  Coefficients are to be written only while the pipeline is empty; the block itself does not enforce this.
//
//  Stages:
//   s1  sign extension, upwind difference select, Laplacians
//   s2  velocity x difference products, Laplacian x coef partial products
//   s3  round to Q16.16; diffusion terms finished with sign
//   s4  advection x coef partial products; center plus diffusion terms
//   s5  advection terms rounded
//   s6  final sum (solid cells pass the center value)
//   s7  saturation into the output register
// ----------------------------------------------------------------------------
module upwind_vorticity_cell_update import uvc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	uvc_in_if.sink               cell_in,
	uvc_out_if.source            cell_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	// effective value width; fields are FIELD_W wide
	localparam int VW = (VALUE_WIDTH < VALUE_WIDTH_MIN) ? VALUE_WIDTH_MIN :
	                    ((VALUE_WIDTH > VALUE_WIDTH_MAX) ? VALUE_WIDTH_MAX : VALUE_WIDTH);
	localparam int LT_W = VW + 4;       // diffusion term
	localparam int CL_W = VW + 6;       // center plus diffusion
	localparam int FX_W = 2 * VW - 14;  // advection term magnitude
	localparam int R_W  = ((CL_W > FX_W) ? CL_W : FX_W) + 2;
	localparam logic signed [R_W-1:0] VMAX = (R_W'(1) << (VW - 1)) - R_W'(1);
	localparam logic signed [R_W-1:0] VMIN = -VMAX - R_W'(1);

	// coefficient registers
	logic [COEF_W-1:0] adv_coef_x_q, adv_coef_y_q, diff_coef_x_q, diff_coef_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_coef_x_q  <= COEF_RESET;
			adv_coef_y_q  <= COEF_RESET;
			diff_coef_x_q <= COEF_RESET;
			diff_coef_y_q <= COEF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ADV_X:  adv_coef_x_q  <= cfg_data;
				REG_ADV_Y:  adv_coef_y_q  <= cfg_data;
				REG_DIFF_X: diff_coef_x_q <= cfg_data;
				REG_DIFF_Y: diff_coef_y_q <= cfg_data;
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// pipeline control: valid bits and per-stage enables
	stage_en_t en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	assign en.s7 = !v_s7 || cell_out.ready;
	assign en.s6 = !v_s6 || en.s7;
	assign en.s5 = !v_s5 || en.s6;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign cell_in.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= cell_in.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
			if (en.s7) v_s7 <= v_s6;
		end
	end

	// s1: stencil front end
	logic signed [VW-1:0] c_s1;
	logic [VW-1:0]        vel_x_mag_s1, vel_y_mag_s1, dif_x_mag_s1, dif_y_mag_s1;
	logic                 adv_x_neg_s1, adv_y_neg_s1;
	logic [VW:0]          lap_x_mag_s1, lap_y_mag_s1;
	logic                 lap_x_neg_s1, lap_y_neg_s1;
	logic                 solid_s1;

	uvc_stencil #(.VW(VW)) u_stencil (
		.clk          (clk),
		.en           (en),
		.vort_center  (cell_in.vort_center),
		.vort_west    (cell_in.vort_west),
		.vort_east    (cell_in.vort_east),
		.vort_south   (cell_in.vort_south),
		.vort_north   (cell_in.vort_north),
		.vel_x        (cell_in.vel_x),
		.vel_y        (cell_in.vel_y),
		.solid_cell   (cell_in.solid_cell),
		.c_s1         (c_s1),
		.vel_x_mag_s1 (vel_x_mag_s1),
		.vel_y_mag_s1 (vel_y_mag_s1),
		.dif_x_mag_s1 (dif_x_mag_s1),
		.dif_y_mag_s1 (dif_y_mag_s1),
		.adv_x_neg_s1 (adv_x_neg_s1),
		.adv_y_neg_s1 (adv_y_neg_s1),
		.lap_x_mag_s1 (lap_x_mag_s1),
		.lap_y_mag_s1 (lap_y_mag_s1),
		.lap_x_neg_s1 (lap_x_neg_s1),
		.lap_y_neg_s1 (lap_y_neg_s1),
		.solid_s1     (solid_s1)
	);

	// s2-s3: diffusion terms
	logic signed [LT_W-1:0] lx_s3, ly_s3;

	uvc_lap_term #(.VW(VW)) u_lap_x (
		.clk        (clk),
		.en         (en),
		.lap_mag_s1 (lap_x_mag_s1),
		.lap_neg_s1 (lap_x_neg_s1),
		.coef       (diff_coef_x_q),
		.term_s3    (lx_s3)
	);

	uvc_lap_term #(.VW(VW)) u_lap_y (
		.clk        (clk),
		.en         (en),
		.lap_mag_s1 (lap_y_mag_s1),
		.lap_neg_s1 (lap_y_neg_s1),
		.coef       (diff_coef_y_q),
		.term_s3    (ly_s3)
	);

	// s2-s5: advection terms
	logic [FX_W-1:0] fx_mag_s5, fy_mag_s5;
	logic            fx_neg_s5, fy_neg_s5;

	uvc_adv_term #(.VW(VW)) u_adv_x (
		.clk        (clk),
		.en         (en),
		.vel_mag_s1 (vel_x_mag_s1),
		.dif_mag_s1 (dif_x_mag_s1),
		.neg_s1     (adv_x_neg_s1),
		.coef       (adv_coef_x_q),
		.mag_s5     (fx_mag_s5),
		.neg_s5     (fx_neg_s5)
	);

	uvc_adv_term #(.VW(VW)) u_adv_y (
		.clk        (clk),
		.en         (en),
		.vel_mag_s1 (vel_y_mag_s1),
		.dif_mag_s1 (dif_y_mag_s1),
		.neg_s1     (adv_y_neg_s1),
		.coef       (adv_coef_y_q),
		.mag_s5     (fy_mag_s5),
		.neg_s5     (fy_neg_s5)
	);

	// center value and solid flag ride along
	logic signed [VW-1:0]   c_s2, c_s3, c_s4, c_s5;
	logic                   solid_s2, solid_s3, solid_s4, solid_s5;
	logic signed [CL_W-1:0] cl_s4, cl_s5;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			c_s2     <= c_s1;
			solid_s2 <= solid_s1;
		end
		if (en.s3) begin
			c_s3     <= c_s2;
			solid_s3 <= solid_s2;
		end
		if (en.s4) begin
			c_s4     <= c_s3;
			solid_s4 <= solid_s3;
			cl_s4    <= CL_W'(c_s3) + CL_W'(lx_s3) + CL_W'(ly_s3);
		end
		if (en.s5) begin
			c_s5     <= c_s4;
			solid_s5 <= solid_s4;
			cl_s5    <= cl_s4;
		end
	end

	// s6: subtract both advection terms; a subtracted negative term adds
	logic signed [R_W-1:0] fx_t, fy_t, sum6;
	logic signed [R_W-1:0] r_s6;

	assign fx_t = $signed(R_W'(fx_mag_s5));
	assign fy_t = $signed(R_W'(fy_mag_s5));
	assign sum6 = R_W'(cl_s5) + (fx_neg_s5 ? fx_t : -fx_t) + (fy_neg_s5 ? fy_t : -fy_t);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			r_s6 <= solid_s5 ? R_W'(c_s5) : sum6;
		end
	end

	// s7: clip to the signed value range
	logic [FIELD_W-1:0] vort_next_s7;
	logic               saturated_s7;
	logic signed [VW-1:0] clip;
	logic               over, under;

	assign over  = r_s6 > VMAX;
	assign under = r_s6 < VMIN;
	assign clip  = over ? VW'(VMAX) : (under ? VW'(VMIN) : VW'(r_s6));

	always_ff @(posedge clk) begin
		if (en.s7) begin
			vort_next_s7 <= FIELD_W'(clip);
			saturated_s7 <= over || under;
		end
	end

	assign cell_out.valid     = v_s7;
	assign cell_out.vort_next = vort_next_s7;
	assign cell_out.saturated = saturated_s7;

endmodule

// ===== hw/rtl/uvc_stencil.sv =====
// ----------------------------------------------------------------------------
// uvc_stencil
// Stage 1: sign-extends the cell word, picks the upwind differences and forms
// the two Laplacians, all as magnitude plus sign.
// ----------------------------------------------------------------------------
module uvc_stencil import uvc_pkg::*; #(
	parameter int VW = VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  stage_en_t           en,
	input  logic [FIELD_W-1:0]  vort_center,
	input  logic [FIELD_W-1:0]  vort_west,
	input  logic [FIELD_W-1:0]  vort_east,
	input  logic [FIELD_W-1:0]  vort_south,
	input  logic [FIELD_W-1:0]  vort_north,
	input  logic [FIELD_W-1:0]  vel_x,
	input  logic [FIELD_W-1:0]  vel_y,
	input  logic                solid_cell,
	output logic signed [VW-1:0] c_s1,
	output logic [VW-1:0]       vel_x_mag_s1,
	output logic [VW-1:0]       vel_y_mag_s1,
	output logic [VW-1:0]       dif_x_mag_s1,
	output logic [VW-1:0]       dif_y_mag_s1,
	output logic                adv_x_neg_s1,
	output logic                adv_y_neg_s1,
	output logic [VW:0]         lap_x_mag_s1,
	output logic [VW:0]         lap_y_mag_s1,
	output logic                lap_x_neg_s1,
	output logic                lap_y_neg_s1,
	output logic                solid_s1
);

	localparam int DW    = VW + 1;  // difference width
	localparam int LAP_W = VW + 2;  // Laplacian width

	logic signed [VW-1:0]    c, w, e, s, n, ux, uy;
	logic                    ux_pos, uy_pos;
	logic signed [DW-1:0]    dx, dy;
	logic signed [LAP_W-1:0] lx, ly;

	assign c  = $signed(vort_center[VW-1:0]);
	assign w  = $signed(vort_west[VW-1:0]);
	assign e  = $signed(vort_east[VW-1:0]);
	assign s  = $signed(vort_south[VW-1:0]);
	assign n  = $signed(vort_north[VW-1:0]);
	assign ux = $signed(vel_x[VW-1:0]);
	assign uy = $signed(vel_y[VW-1:0]);

	// zero velocity takes the forward difference
	assign ux_pos = !ux[VW-1] && (|ux);
	assign uy_pos = !uy[VW-1] && (|uy);

	assign dx = ux_pos ? (DW'(c) - DW'(w)) : (DW'(e) - DW'(c));
	assign dy = uy_pos ? (DW'(c) - DW'(s)) : (DW'(n) - DW'(c));

	assign lx = LAP_W'(e) + LAP_W'(w) - (LAP_W'(c) <<< 1);
	assign ly = LAP_W'(n) + LAP_W'(s) - (LAP_W'(c) <<< 1);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			c_s1         <= c;
			vel_x_mag_s1 <= ux[VW-1] ? VW'(-ux) : VW'(ux);
			vel_y_mag_s1 <= uy[VW-1] ? VW'(-uy) : VW'(uy);
			dif_x_mag_s1 <= dx[DW-1] ? VW'(-dx) : VW'(dx);
			dif_y_mag_s1 <= dy[DW-1] ? VW'(-dy) : VW'(dy);
			adv_x_neg_s1 <= ux[VW-1] ^ dx[DW-1];
			adv_y_neg_s1 <= uy[VW-1] ^ dy[DW-1];
			lap_x_mag_s1 <= lx[LAP_W-1] ? (VW+1)'(-lx) : (VW+1)'(lx);
			lap_y_mag_s1 <= ly[LAP_W-1] ? (VW+1)'(-ly) : (VW+1)'(ly);
			lap_x_neg_s1 <= lx[LAP_W-1];
			lap_y_neg_s1 <= ly[LAP_W-1];
			solid_s1     <= solid_cell;
		end
	end

endmodule

// ===== hw/rtl/uvc_lap_term.sv =====
// ----------------------------------------------------------------------------
// uvc_lap_term
// Stages 2-3: diffusion term, Laplacian times a Q2.30 coefficient, rounded
// half away from zero to Q16.16.
// ----------------------------------------------------------------------------
module uvc_lap_term import uvc_pkg::*; #(
	parameter int VW = VALUE_WIDTH_DEF
) (
	input  logic                  clk,
	input  stage_en_t             en,
	input  logic [VW:0]           lap_mag_s1,
	input  logic                  lap_neg_s1,
	input  logic [COEF_W-1:0]     coef,
	output logic signed [VW+3:0]  term_s3
);

	localparam int MAG_W = VW + 1;
	localparam int LO_W  = (MAG_W + 1) / 2;
	localparam int HI_W  = MAG_W - LO_W;
	localparam int P_W   = MAG_W + COEF_W;
	localparam int R_W   = P_W - COEF_FRAC_W;
	localparam int T_W   = VW + 4;
	localparam logic [P_W-1:0] HALF = P_W'(1) << (COEF_FRAC_W - 1);

	logic [LO_W+COEF_W-1:0] lo_s2;
	logic [HI_W+COEF_W-1:0] hi_s2;
	logic                   neg_s2;
	logic [P_W-1:0]         sum;
	logic [R_W-1:0]         mag;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			lo_s2  <= lap_mag_s1[LO_W-1:0] * coef;
			hi_s2  <= lap_mag_s1[MAG_W-1:LO_W] * coef;
			neg_s2 <= lap_neg_s1;
		end
	end

	assign sum = (P_W'(hi_s2) << LO_W) + P_W'(lo_s2) + HALF;
	assign mag = sum[P_W-1:COEF_FRAC_W];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			term_s3 <= neg_s2 ? -$signed(T_W'(mag)) : $signed(T_W'(mag));
		end
	end

endmodule

// ===== hw/rtl/uvc_adv_term.sv =====
// ----------------------------------------------------------------------------
// uvc_adv_term
// Stages 2-5: advection term magnitude. Velocity times upwind difference,
// rounded to Q16.16, then times a Q2.30 coefficient and rounded again.
// ----------------------------------------------------------------------------
module uvc_adv_term import uvc_pkg::*; #(
	parameter int VW = VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  stage_en_t            en,
	input  logic [VW-1:0]        vel_mag_s1,
	input  logic [VW-1:0]        dif_mag_s1,
	input  logic                 neg_s1,
	input  logic [COEF_W-1:0]    coef,
	output logic [2*VW-15:0]     mag_s5,
	output logic                 neg_s5
);

	localparam int PR_W  = 2 * VW;          // raw product, Q32.32
	localparam int AR_W  = PR_W - FRAC_W;   // rounded to Q16.16
	localparam int ALO_W = (AR_W + 1) / 2;
	localparam int AHI_W = AR_W - ALO_W;
	localparam int P_W   = AR_W + COEF_W;
	localparam logic [PR_W-1:0] HALF16 = PR_W'(1) << (FRAC_W - 1);
	localparam logic [P_W-1:0]  HALF30 = P_W'(1) << (COEF_FRAC_W - 1);

	logic [PR_W-1:0]         prod_s2;
	logic                    neg_s2, neg_s3, neg_s4;
	logic [PR_W-1:0]         prod_rnd;
	logic [AR_W-1:0]         rnd_s3;
	logic [ALO_W+COEF_W-1:0] lo_s4;
	logic [AHI_W+COEF_W-1:0] hi_s4;
	logic [P_W-1:0]          sum;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= vel_mag_s1 * dif_mag_s1;
			neg_s2  <= neg_s1;
		end
	end

	assign prod_rnd = prod_s2 + HALF16;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			rnd_s3 <= prod_rnd[PR_W-1:FRAC_W];
			neg_s3 <= neg_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			lo_s4  <= rnd_s3[ALO_W-1:0] * coef;
			hi_s4  <= rnd_s3[AR_W-1:ALO_W] * coef;
			neg_s4 <= neg_s3;
		end
	end

	assign sum = (P_W'(hi_s4) << ALO_W) + P_W'(lo_s4) + HALF30;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			mag_s5 <= sum[P_W-1:COEF_FRAC_W];
			neg_s5 <= neg_s4;
		end
	end

endmodule
